// ===== hw/rtl/fsde_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsde_pkg
// shared types and constants of the fat short directory entry decoder
// ----------------------------------------------------------------------------
package fsde_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned BASE_LANES  = 8;
  localparam int unsigned EXT_LANES   = 3;
  localparam int unsigned NAME_CHARS  = 12;
  localparam int unsigned NAME_W      = NAME_CHARS * CHAR_W;
  localparam int unsigned HEAD_W      = BASE_LANES * CHAR_W;
  localparam int unsigned TAIL_W      = NAME_W - HEAD_W;
  localparam int unsigned EXT_W       = EXT_LANES * CHAR_W;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned ATTR_W      = 8;
  localparam int unsigned HALF_W      = 16;
  localparam int unsigned CLUSTER_W   = 2 * HALF_W;
  localparam int unsigned IN_TDATA_W  = 128;
  localparam int unsigned OUT_TDATA_W = 136;
  localparam int unsigned DIR_BIT     = 4;

  localparam logic [CHAR_W-1:0] DELETED_MARK   = 8'hE5;
  localparam logic [CHAR_W-1:0] SPACE_CHAR     = 8'h20;
  localparam logic [CHAR_W-1:0] DOT_CHAR       = 8'h2E;
  localparam logic [5:0]        LONG_NAME_ATTR = 6'h0F;

  typedef enum logic [1:0] {
    STAT_VALID = 2'd0,
    STAT_SKIP  = 2'd1,
    STAT_END   = 2'd2
  } status_e;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_space;
    logic              is_zero;
  } lane_t;

  typedef struct packed {
    status_e              status;
    logic [HEAD_W-1:0]    name_head;
    logic [TAIL_W-1:0]    name_tail;
    logic [LEN_W-1:0]     name_length;
    logic [CLUSTER_W-1:0] first_cluster;
    logic                 is_directory;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fsde_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsde_lane
// per-character classifier: space and zero detection for one name byte
// ----------------------------------------------------------------------------
module fsde_lane (
  input  logic [fsde_pkg::CHAR_W-1:0] char_i,
  output fsde_pkg::lane_t             lane_o
);

  assign lane_o.ch       = char_i;
  assign lane_o.is_space = (char_i == fsde_pkg::SPACE_CHAR);
  assign lane_o.is_zero  = (char_i == '0);

endmodule
`default_nettype wire

// ===== hw/rtl/fsde_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsde_merge
// combines lane results into the compacted 8.3 name and its length
// ----------------------------------------------------------------------------
module fsde_merge (
  input  fsde_pkg::lane_t                base_lanes_i [fsde_pkg::BASE_LANES],
  input  fsde_pkg::lane_t                ext_lanes_i  [fsde_pkg::EXT_LANES],
  output logic [fsde_pkg::HEAD_W-1:0]    name_head_o,
  output logic [fsde_pkg::TAIL_W-1:0]    name_tail_o,
  output logic [fsde_pkg::LEN_W-1:0]     name_length_o
);

  localparam int unsigned DOT_W = (fsde_pkg::EXT_LANES + 1) * fsde_pkg::CHAR_W;

  logic                        run;
  logic                        ext_on;
  logic [fsde_pkg::LEN_W-1:0]  base_len;
  logic [fsde_pkg::LEN_W-1:0]  ext_len;
  logic [fsde_pkg::NAME_W-1:0] base_part;
  logic [DOT_W-1:0]            dot_part;
  logic [fsde_pkg::NAME_W-1:0] name;

  always_comb begin
    base_part = '0;
    base_len  = '0;
    run       = 1'b1;
    for (int i = 0; i < fsde_pkg::BASE_LANES; i++) begin
      run = run & ~base_lanes_i[i].is_space;
      if (run) begin
        base_part[fsde_pkg::CHAR_W*i +: fsde_pkg::CHAR_W] = base_lanes_i[i].ch;
        base_len = base_len + fsde_pkg::LEN_W'(1);
      end
    end

    // dot followed by the extension up to its first space
    ext_on   = ~ext_lanes_i[0].is_space;
    dot_part = '0;
    dot_part[fsde_pkg::CHAR_W-1:0] = fsde_pkg::DOT_CHAR;
    ext_len  = '0;
    run      = 1'b1;
    for (int i = 0; i < fsde_pkg::EXT_LANES; i++) begin
      run = run & ~ext_lanes_i[i].is_space;
      if (run) begin
        dot_part[fsde_pkg::CHAR_W*(i+1) +: fsde_pkg::CHAR_W] = ext_lanes_i[i].ch;
        ext_len = ext_len + fsde_pkg::LEN_W'(1);
      end
    end
    if (!ext_on) begin
      dot_part = '0;
    end

    name = base_part | (fsde_pkg::NAME_W'(dot_part) << {base_len, 3'b000});
    name_length_o = ext_on ? base_len + ext_len + fsde_pkg::LEN_W'(1) : base_len;
    name_head_o   = name[fsde_pkg::HEAD_W-1:0];
    name_tail_o   = name[fsde_pkg::NAME_W-1:fsde_pkg::HEAD_W];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fat_short_dir_entry_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fat_short_dir_entry_decoder
// decodes one fat 8.3 directory entry per request into name, cluster, status
// ----------------------------------------------------------------------------
// channel   dir  tdata                                     tuser
// s_axis    in   base, extension, attributes, cluster lo/hi directory_start
// m_axis    out  name head/tail, length, cluster, dir flag  status
//
// one request per cycle while s_axis_tready_o is high; results are registered.
// the eleven character lanes and the merge stage sit before the output register.
// a two-entry output register (main plus skid) keeps s_axis_tready_o free of
// m_axis_tready_i; it drops only while the skid entry holds a result.
// reset clears the sticky end flag and the valid flags of both output entries.
// ----------------------------------------------------------------------------
module fat_short_dir_entry_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // name_base[63:0], name_extension[87:64], attributes[95:88],
  // clus_lo[111:96], clus_hi[127:112]
  input  logic [fsde_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // directory_start[0]
  input  logic                                 s_axis_tuser_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // name_head[63:0], name_tail[95:64], name_length[99:96],
  // first_cluster[131:100], is_directory[132], zero[135:133]
  output logic [fsde_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]                           m_axis_tuser_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i
);

  localparam int unsigned PAY_W = fsde_pkg::HEAD_W + fsde_pkg::TAIL_W + fsde_pkg::LEN_W
                                  + fsde_pkg::CLUSTER_W + 1;

  logic [fsde_pkg::HEAD_W-1:0]    name_base;
  logic [fsde_pkg::EXT_W-1:0]     name_extension;
  logic [fsde_pkg::ATTR_W-1:0]    attributes;
  logic [fsde_pkg::HALF_W-1:0]    clus_lo;
  logic [fsde_pkg::HALF_W-1:0]    clus_hi;

  fsde_pkg::lane_t                base_lanes [fsde_pkg::BASE_LANES];
  fsde_pkg::lane_t                ext_lanes  [fsde_pkg::EXT_LANES];
  logic [fsde_pkg::HEAD_W-1:0]    name_head;
  logic [fsde_pkg::TAIL_W-1:0]    name_tail;
  logic [fsde_pkg::LEN_W-1:0]     name_length;

  logic                           in_fire;
  logic                           end_q, end_d;
  logic                           skip;
  fsde_pkg::result_t              res;
  fsde_pkg::result_t              out_q, out_d, skid_q, skid_d;
  logic                           out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign name_base      = s_axis_tdata_i[63:0];
  assign name_extension = s_axis_tdata_i[87:64];
  assign attributes     = s_axis_tdata_i[95:88];
  assign clus_lo        = s_axis_tdata_i[111:96];
  assign clus_hi        = s_axis_tdata_i[127:112];

  for (genvar g = 0; g < fsde_pkg::BASE_LANES; g++) begin : g_base
    fsde_lane u_lane (
      .char_i (name_base[fsde_pkg::CHAR_W*g +: fsde_pkg::CHAR_W]),
      .lane_o (base_lanes[g])
    );
  end

  for (genvar g = 0; g < fsde_pkg::EXT_LANES; g++) begin : g_ext
    fsde_lane u_lane (
      .char_i (name_extension[fsde_pkg::CHAR_W*g +: fsde_pkg::CHAR_W]),
      .lane_o (ext_lanes[g])
    );
  end

  fsde_merge u_merge (
    .base_lanes_i  (base_lanes),
    .ext_lanes_i   (ext_lanes),
    .name_head_o   (name_head),
    .name_tail_o   (name_tail),
    .name_length_o (name_length)
  );

  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    end_d = s_axis_tuser_i ? 1'b0 : end_q;
    if (base_lanes[0].is_zero) begin
      end_d = 1'b1;
    end
    skip = (base_lanes[0].ch == fsde_pkg::DELETED_MARK)
         | (attributes[5:0] == fsde_pkg::LONG_NAME_ATTR);

    res = '0;
    if (end_d) begin
      res.status = fsde_pkg::STAT_END;
    end else if (skip) begin
      res.status = fsde_pkg::STAT_SKIP;
    end else begin
      res.status        = fsde_pkg::STAT_VALID;
      res.name_head     = name_head;
      res.name_tail     = name_tail;
      res.name_length   = name_length;
      res.first_cluster = {clus_hi, clus_lo};
      res.is_directory  = attributes[fsde_pkg::DIR_BIT];
    end
  end

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (m_axis_tready_i) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || m_axis_tready_i) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        end_q <= end_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign s_axis_tready_o = ~skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = fsde_pkg::OUT_TDATA_W'({out_q.is_directory, out_q.first_cluster,
                                                   out_q.name_length, out_q.name_tail,
                                                   out_q.name_head});

  // skid entry only fills behind a held main entry
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without main entry");

  // a zero first byte always leaves the end flag set
  a_end_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && base_lanes[0].is_zero) |=> end_q)
    else $error("end flag not set after end marker");

  // skipped and end results carry an all-zero payload
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != fsde_pkg::STAT_VALID))
      |-> (m_axis_tdata_o[PAY_W-1:0] == '0))
    else $error("non-valid result with nonzero payload");

  // no result holds a name longer than twelve characters
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_q.name_length <= fsde_pkg::LEN_W'(fsde_pkg::NAME_CHARS)))
    else $error("name length out of range");

endmodule
`default_nettype wire
